FILE: sv/upq_pkg.sv
// Shared constants and types for the unsorted array priority queue.
// No dependencies; imported by the core, the checker and the testbench.
package upq_pkg;

  localparam int CAPACITY = 8;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OCC_W    = 4;
  localparam int STAT_W   = 2;
  localparam int OUT_W    = DATA_W + STAT_W + OCC_W;
  localparam int M_DATA_W = ((OUT_W + 7) / 8) * 8;
  localparam int PAD_W    = M_DATA_W - OUT_W;

  typedef logic signed [DATA_W-1:0] value_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

endpackage

FILE: sv/upq_ram.sv
// Simple dual-port entry memory: one write port, one read port, registered read data.
// No dependencies.
module upq_ram #(
  parameter int DEPTH  = 8,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/unsorted_array_priority_queue_core.sv
// Minimum priority queue over an unordered entry memory, one item in flight.
// Depends on upq_pkg and upq_ram.
// An insert or a refused item (overflow, underflow) goes from the idle state to
// the done state, which raises its result once the output is free. A delete on
// a queue of n entries passes through the scan and shift states: the single read
// port of the entry memory is swept once over all n entries to find the minimum
// (lowest position wins ties), then again over the entries above it, each read
// written back one place lower in the next cycle. The next transfer can be taken
// in the cycle the result is raised. The memory needs no clearing after reset.
// The result register lets the next item enter while the previous result waits.
module unsorted_array_priority_queue_core
  import upq_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [DATA_W-1:0]   s_tdata,   // [31:0] value
  input  logic                s_tuser,   // [0] op
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata    // [31:0] removed_value, [33:32] status,
                                         // [37:34] occupancy, rest zero
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  rd_idx;
  logic [CNT_W-1:0]  rd_pos;
  logic [CNT_W-1:0]  wr_pos;
  logic              rd_vld;
  logic              issue;
  value_t            rd_data;
  value_t            best;
  logic [CNT_W-1:0]  best_pos;
  value_t            res_value;
  status_t           res_status;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  value_t            wr_data;
  logic              ins_ok;
  logic              out_free;

  assign s_tready = (state == S_IDLE);
  assign issue    = ((state == S_SCAN) || (state == S_SHIFT)) && (rd_idx < count);
  assign ins_ok   = s_tvalid && s_tready && (op_t'(s_tuser) == OP_INSERT)
                    && (count != CNT_W'(CAPACITY));
  assign out_free = !m_tvalid || m_tready;
  assign wr_pos   = rd_pos - 1'b1;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[IDX_W-1:0];
    wr_data = s_tdata;
    if (ins_ok) begin
      wr_en = 1'b1;
    end else if ((state == S_SHIFT) && rd_vld) begin
      wr_en   = 1'b1;
      wr_addr = wr_pos[IDX_W-1:0];
      wr_data = rd_data;
    end
  end

  upq_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (issue),
    .rd_addr (rd_idx[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      rd_vld   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      rd_vld <= issue;
      if ((state == S_DONE) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            if (op_t'(s_tuser) == OP_DELETE) begin
              if (count == '0) begin
                state <= S_DONE;
              end else begin
                rd_idx <= '0;
                state  <= S_SCAN;
              end
            end else begin
              if (ins_ok) begin
                count <= count + 1'b1;
              end
              state <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          if (issue) begin
            rd_idx <= rd_idx + 1'b1;
          end
          if (!issue && !rd_vld) begin
            rd_idx <= best_pos + 1'b1;
            state  <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (issue) begin
            rd_idx <= rd_idx + 1'b1;
          end
          if (!issue && !rd_vld) begin
            count <= count - 1'b1;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload: scan tracking, result fields, output register
  always_ff @(posedge clk) begin
    rd_pos <= rd_idx;
    if ((state == S_SCAN) && rd_vld) begin
      if ((rd_pos == '0) || (rd_data < best)) begin
        best     <= rd_data;
        best_pos <= rd_pos;
      end
    end
    if (state == S_IDLE && s_tvalid) begin
      res_value <= '0;
      if (op_t'(s_tuser) == OP_DELETE) begin
        res_status <= (count == '0) ? ST_UNDERFLOW : ST_OK;
      end else begin
        res_status <= (count == CNT_W'(CAPACITY)) ? ST_OVERFLOW : ST_OK;
      end
    end else if ((state == S_SHIFT) && !issue && !rd_vld) begin
      res_value <= best;
    end
    if ((state == S_DONE) && out_free) begin
      m_tdata <= {{PAD_W{1'b0}}, OCC_W'(count), res_status, res_value};
    end
  end

endmodule

FILE: sv/upq_checker.sv
// Port-level checks for the priority queue core, bound to the top level.
// Depends on upq_pkg and unsorted_array_priority_queue_core.
module upq_checker
  import upq_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata
);

  logic [STAT_W-1:0] st;
  logic [OCC_W-1:0]  occ;
  logic [DATA_W-1:0] rv;

  assign rv  = m_tdata[DATA_W-1:0];
  assign st  = m_tdata[DATA_W+STAT_W-1:DATA_W];
  assign occ = m_tdata[OUT_W-1:DATA_W+STAT_W];

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second transfer accepted while busy");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (st != ST_OK) |-> (rv == '0))
    else $error("refused item carries a nonzero value");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (st == ST_OVERFLOW) |-> (occ == OCC_W'(CAPACITY)))
    else $error("overflow reported on a queue that is not full");

  a_underflow_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (st == ST_UNDERFLOW) |-> (occ == '0))
    else $error("underflow reported on a queue that is not empty");

endmodule

bind unsorted_array_priority_queue_core upq_checker u_upq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: sim/unsorted_array_priority_queue_core_tb.sv
// Self-checking testbench for unsorted_array_priority_queue_core: a directed table, then
// random insert/delete bursts, checked by an in-bench queue predictor or fixed results.
// Depends on upq_pkg and the core RTL.
module unsorted_array_priority_queue_core_tb;
  import upq_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 48;
  localparam int RANDOM_ITEMS   = 1050;
  localparam int MAX_REPORTS    = 10;
  localparam int DIRECTED_ROWS  = 21;

  typedef struct packed {
    logic [DATA_W-1:0] removed;
    status_t           status;
    logic [OCC_W-1:0]  occupancy;
  } queue_result_t;

  typedef struct packed {
    op_t           op;
    value_t        value;
    logic          fixed;
    queue_result_t result;
  } stim_row_t;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [DATA_W-1:0]   s_tdata  = '0;   // [31:0] value
  logic                s_tuser  = 1'b0; // [0] op
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;         // [31:0] removed_value, [33:32] status,
                                        // [37:34] occupancy, rest zero

  value_t        queue_vals [CAPACITY];
  int            queue_count = 0;
  queue_result_t pending_results [$];
  int            mismatches  = 0;
  int            sender_idle_pct = 0;
  int            receiver_stall_pct = 0;
  int            quiet_cycles = 0;
  stim_row_t     directed_rows [DIRECTED_ROWS];

  unsorted_array_priority_queue_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #1 clk = ~clk;

  // Applies one operation to the queue copy and returns the result it yields.
  function automatic queue_result_t apply_queue_op(input op_t op, input value_t v);
    queue_result_t r;
    int            min_pos;
    r.removed = '0;
    r.status  = ST_OK;
    if (op == OP_INSERT) begin
      if (queue_count >= CAPACITY) begin
        r.status = ST_OVERFLOW;
      end else begin
        queue_vals[queue_count] = v;
        queue_count++;
      end
    end else if (queue_count == 0) begin
      r.status = ST_UNDERFLOW;
    end else begin
      min_pos = 0;
      for (int i = 1; i < queue_count; i++) begin
        if (queue_vals[i] < queue_vals[min_pos]) min_pos = i;
      end
      r.removed = queue_vals[min_pos];
      for (int i = min_pos + 1; i < queue_count; i++) queue_vals[i-1] = queue_vals[i];
      queue_count--;
    end
    r.occupancy = OCC_W'(queue_count);
    return r;
  endfunction

  function automatic value_t pick_value();
    value_t v;
    case ($urandom_range(5))
      0: begin
        case ($urandom_range(4))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7FFF_FFFF;
          2: v = 32'sd0;
          3: v = -32'sd1;
          default: v = 32'sd1;
        endcase
      end
      1, 2: v = value_t'($urandom_range(6)) - 32'sd3;  // narrow range, many ties
      default: v = value_t'($urandom);
    endcase
    return v;
  endfunction

  task automatic send_item(input op_t op, input value_t v, input logic fixed,
                           input queue_result_t fixed_result);
    queue_result_t predicted;
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    predicted = apply_queue_op(op, v);
    pending_results.push_back(fixed ? fixed_result : predicted);
  endtask

  // Receiver side backpressure.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    queue_result_t exp_r;
    queue_result_t got_r;
    logic          bad;
    if (!rst && m_tvalid && m_tready) begin
      got_r.removed   = m_tdata[DATA_W-1:0];
      got_r.status    = status_t'(m_tdata[DATA_W +: STAT_W]);
      got_r.occupancy = m_tdata[DATA_W+STAT_W +: OCC_W];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: removed=%h status=%0d occupancy=%0d",
                   got_r.removed, got_r.status, got_r.occupancy);
      end else begin
        exp_r = pending_results.pop_front();
        bad = (got_r.removed !== exp_r.removed) || (got_r.status !== exp_r.status) ||
              (got_r.occupancy !== exp_r.occupancy) ||
              (m_tdata[M_DATA_W-1:OUT_W] !== '0);
        if (bad) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected removed=%h status=%0d occupancy=%0d, got %h",
                     exp_r.removed, exp_r.status, exp_r.occupancy, m_tdata);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("unsorted_array_priority_queue_core_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    op_t    op;
    int     insert_pct;
    int     burst_left;
    int     idle_phase [4];
    int     stall_phase [4];
    idle_phase  = '{0, 78, 0, 23};
    stall_phase = '{0, 0, 78, 23};

    directed_rows = '{
      '{OP_DELETE, 32'sd0,           1'b1, '{32'h0, ST_UNDERFLOW, 4'd0}},
      '{OP_INSERT, 32'sh7FFF_FFFF,   1'b1, '{32'h0, ST_OK, 4'd1}},
      '{OP_INSERT, 32'sh8000_0000,   1'b1, '{32'h0, ST_OK, 4'd2}},
      '{OP_INSERT, 32'sd0,           1'b0, '0},
      '{OP_INSERT, -32'sd1,          1'b0, '0},
      '{OP_INSERT, 32'sd5,           1'b0, '0},
      '{OP_INSERT, -32'sd1,          1'b0, '0},
      '{OP_INSERT, 32'sd1,           1'b0, '0},
      '{OP_INSERT, 32'sh8000_0000,   1'b1, '{32'h0, ST_OK, 4'd8}},
      '{OP_INSERT, 32'sd42,          1'b1, '{32'h0, ST_OVERFLOW, 4'd8}},
      '{OP_DELETE, 32'sd0,           1'b1, '{32'h8000_0000, ST_OK, 4'd7}},
      '{OP_DELETE, 32'sh7FFF_FFFF,   1'b1, '{32'h8000_0000, ST_OK, 4'd6}},
      '{OP_DELETE, 32'sd0,           1'b0, '0},
      '{OP_INSERT, 32'sh5A5A_A5A5,   1'b0, '0},
      '{OP_DELETE, -32'sd1,          1'b0, '0},
      '{OP_DELETE, 32'sd0,           1'b0, '0},
      '{OP_DELETE, 32'sd0,           1'b0, '0},
      '{OP_DELETE, 32'sd0,           1'b0, '0},
      '{OP_DELETE, 32'sd0,           1'b0, '0},
      '{OP_DELETE, 32'sd0,           1'b1, '{32'h7FFF_FFFF, ST_OK, 4'd0}},
      '{OP_DELETE, 32'sd0,           1'b1, '{32'h0, ST_UNDERFLOW, 4'd0}}
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].value, directed_rows[i].fixed,
                directed_rows[i].result);

    burst_left = 0;
    insert_pct = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % (RANDOM_ITEMS / 4) == 0 && n / (RANDOM_ITEMS / 4) < 4) begin
        sender_idle_pct    = idle_phase[n / (RANDOM_ITEMS / 4)];
        receiver_stall_pct = stall_phase[n / (RANDOM_ITEMS / 4)];
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(24, 6);
        case ($urandom_range(2))
          0: insert_pct = 20;
          1: insert_pct = 50;
          default: insert_pct = 80;
        endcase
      end
      burst_left--;
      op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_DELETE;
      send_item(op, pick_value(), 1'b0, '0);
    end
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("unsorted_array_priority_queue_core_tb OK");
    end else begin
      $display("unsorted_array_priority_queue_core_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/upq_pkg.sv
sv/upq_ram.sv
sv/unsorted_array_priority_queue_core.sv
sv/upq_checker.sv
sim/unsorted_array_priority_queue_core_tb.sv
